/* hw/rtl/fpexp_pkg.sv */
// shared types, constants and tables of the fixed-point exponential pipeline
package fpexp_pkg;

	localparam int VAL_W = 50;
	localparam int CO_W = 32;
	localparam int DLOW_W = 11;
	localparam int IDX_W = 5;

	localparam logic signed [31:0] HI_LIMIT = 32'sd363408;
	localparam logic signed [31:0] LO_LIMIT = -32'sd340695;
	localparam logic [31:0] SAT_HIGH = 32'd2147483647;
	localparam logic [31:0] ARG_OFFSET = 32'd524288;

	localparam logic [31:0] SER_C0 = 32'd5294;
	localparam logic [31:0] SER_C1 = 32'd4293434720;
	localparam logic [31:0] SER_C2 = 32'd2081624032;

	typedef struct packed {
		logic func;
		logic sat_hi;
		logic sat_lo;
		logic zero;
	} meta_t;

	// exp(k) * 2^32 for k = -13..12, indexed by k + 13
	function automatic logic [VAL_W-1:0] exp_int(input logic [IDX_W-1:0] idx);
		logic [VAL_W-1:0] r;
		unique case (idx)
			5'd0: r = 50'd9708;
			5'd1: r = 50'd26389;
			5'd2: r = 50'd71733;
			5'd3: r = 50'd194991;
			5'd4: r = 50'd530041;
			5'd5: r = 50'd1440801;
			5'd6: r = 50'd3916503;
			5'd7: r = 50'd10646160;
			5'd8: r = 50'd28939262;
			5'd9: r = 50'd78665070;
			5'd10: r = 50'd213833830;
			5'd11: r = 50'd581260615;
			5'd12: r = 50'd1580030169;
			5'd13: r = 50'd4294967296;
			5'd14: r = 50'd11674931555;
			5'd15: r = 50'd31735754293;
			5'd16: r = 50'd86266724208;
			5'd17: r = 50'd234497268814;
			5'd18: r = 50'd637429664642;
			5'd19: r = 50'd1732713474316;
			5'd20: r = 50'd4710003551159;
			5'd21: r = 50'd12803117065094;
			5'd22: r = 50'd34802480465680;
			5'd23: r = 50'd94602950235157;
			5'd24: r = 50'd257157480542844;
			5'd25: r = 50'd699026506411923;
			default: r = '0;
		endcase
		return r;
	endfunction

	// (1 - exp(-j/16)) * 2^32
	function automatic logic [CO_W-1:0] coarse(input logic [3:0] j);
		logic [CO_W-1:0] r;
		unique case (j)
			4'd0: r = 32'd0;
			4'd1: r = 32'd260218914;
			4'd2: r = 32'd504671961;
			4'd3: r = 32'd734314346;
			4'd4: r = 32'd950043403;
			4'd5: r = 32'd1152702096;
			4'd6: r = 32'd1343082321;
			4'd7: r = 32'd1521927990;
			4'd8: r = 32'd1689937949;
			4'd9: r = 32'd1847768698;
			4'd10: r = 32'd1996036966;
			4'd11: r = 32'd2135322113;
			4'd12: r = 32'd2266168400;
			4'd13: r = 32'd2389087112;
			4'd14: r = 32'd2504558555;
			default: r = 32'd2613033936;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/fpexp_front.sv */
// argument decode, range checks and table lookups (first pipeline stage)
module fpexp_front (
	input  logic                            clk,
	input  logic                            en,
	input  logic                            func,
	input  logic signed [31:0]              arg,
	output fpexp_pkg::meta_t                meta_d,
	output logic [fpexp_pkg::VAL_W-1:0]     v0_s1,
	output logic [fpexp_pkg::CO_W-1:0]      c_s1,
	output logic [fpexp_pkg::DLOW_W-1:0]    dlow_s1
);
	import fpexp_pkg::*;

	logic [31:0] u;
	logic [IDX_W-1:0] ui;
	logic [14:0] f;
	logic [14:0] d;
	logic [IDX_W-1:0] idx;
	logic zero;

	always_comb begin
		u = $unsigned(arg) + ARG_OFFSET;
		ui = u[19:15];
		f = u[14:0];
		zero = (f == 15'd0);
		// d = 32768 - f, which wraps to zero for an exact integer
		d = 15'(~f + 15'd1);
		// integer part rounds up unless the fraction is zero
		idx = zero ? ui - 5'd3 : ui - 5'd2;
		meta_d.func = func;
		meta_d.sat_hi = (arg > HI_LIMIT);
		meta_d.sat_lo = (arg < LO_LIMIT);
		meta_d.zero = zero;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v0_s1 <= exp_int(idx);
			c_s1 <= coarse(d[14:11]);
			dlow_s1 <= d[10:0];
		end
	end

endmodule

/* hw/rtl/fpexp_scale.sv */
// two-stage reduction v - floor(v * c / 2^32)
module fpexp_scale (
	input  logic                            clk,
	input  logic                            en_a,
	input  logic                            en_b,
	input  logic [fpexp_pkg::VAL_W-1:0]     v,
	input  logic [fpexp_pkg::CO_W-1:0]      c,
	output logic [fpexp_pkg::VAL_W-1:0]     res_s2
);
	import fpexp_pkg::*;

	logic [63:0] plo;
	logic [VAL_W-1:0] phi;
	logic [31:0] plo_s1;
	logic [VAL_W-1:0] phi_s1;
	logic [VAL_W-1:0] v_s1;

	always_comb begin
		plo = 64'(v[31:0]) * 64'(c);
		phi = VAL_W'(v[VAL_W-1:32]) * VAL_W'(c);
	end

	always_ff @(posedge clk) begin
		if (en_a) begin
			plo_s1 <= plo[63:32];
			phi_s1 <= phi;
			v_s1 <= v;
		end
		if (en_b) begin
			res_s2 <= v_s1 - (phi_s1 + VAL_W'(plo_s1));
		end
	end

endmodule

/* hw/rtl/fpexp_series.sv */
// quadratic series for the low fraction bits, four stages
module fpexp_series (
	input  logic                            clk,
	input  logic [3:0]                      en,
	input  logic [fpexp_pkg::DLOW_W-1:0]    dlow,
	input  logic                            zero,
	output logic [fpexp_pkg::CO_W-1:0]      s_s4
);
	import fpexp_pkg::*;

	logic [42:0] m1_s1;
	logic [DLOW_W-1:0] dlow_s1;
	logic [31:0] t1_s2;
	logic [DLOW_W-1:0] dlow_s2;
	logic [42:0] m2_s3;

	// the argument y is dlow << 17, so each high product is a shift by 15
	always_ff @(posedge clk) begin
		if (en[0]) begin
			m1_s1 <= 43'(SER_C2) * 43'(dlow);
			dlow_s1 <= dlow;
		end
		if (en[1]) begin
			t1_s2 <= SER_C1 - 32'(m1_s1[42:15]);
			dlow_s2 <= dlow_s1;
		end
		if (en[2]) begin
			m2_s3 <= 43'(t1_s2) * 43'(dlow_s2);
		end
		if (en[3]) begin
			// exact integer argument skips the reduction
			s_s4 <= zero ? '0 : 32'(m2_s3[42:15]) + SER_C0;
		end
	end

endmodule

/* hw/rtl/fixed_point_exponential.sv */
// top level of the pipelined fixed-point exponential
// Computes exp of an s16.15 argument, one item per cycle when the output side keeps ready
// high. An accepted item moves through the stages in order into the result register, where
// it is taken while ready is high. There are eight stages: decode and table lookup, two for
// the coarse 32-bit multiply and subtract, and a parallel four-stage series unit, then two
// for the fine multiply and subtract, and a format/saturation output register. Each stage
// holds when the next is full and stalled, so the pipeline compacts bubbles and takes a new
// item whenever any stage can move. Arguments above 363408 give 2147483647, below -340695
// give 0; func 0 returns s16.15, func 1 the low 32 bits as an unsigned 0.32 fraction.
module fixed_point_exponential (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [31:0] arg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        value
);
	import fpexp_pkg::*;

	localparam int NSTG = 8;

	logic [NSTG-1:0] valid_q;
	logic [NSTG-1:0] en;
	meta_t meta_q [NSTG];
	meta_t meta_d;

	logic [VAL_W-1:0] v0_s1;
	logic [CO_W-1:0] c_s1;
	logic [DLOW_W-1:0] dlow_s1;
	logic [VAL_W-1:0] v1_s3;
	logic [VAL_W-1:0] v1_s4;
	logic [VAL_W-1:0] v1_s5;
	logic [CO_W-1:0] s_s5;
	logic [VAL_W-1:0] v2_s7;
	logic [31:0] value_s8;

	// a stage moves when it is empty or the stage after it moves
	always_comb begin
		en[NSTG-1] = !valid_q[NSTG-1] || out_ready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			en[i] = !valid_q[i] || en[i+1];
		end
	end

	assign in_ready = en[0];
	assign out_valid = valid_q[NSTG-1];
	assign value = value_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (en[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			meta_q[0] <= meta_d;
		end
		for (int i = 1; i < NSTG; i++) begin
			if (en[i]) begin
				meta_q[i] <= meta_q[i-1];
			end
		end
	end

	fpexp_front u_front (
		.clk     (clk),
		.en      (en[0]),
		.func    (func),
		.arg     (arg),
		.meta_d  (meta_d),
		.v0_s1   (v0_s1),
		.c_s1    (c_s1),
		.dlow_s1 (dlow_s1)
	);

	fpexp_scale u_coarse (
		.clk    (clk),
		.en_a   (en[1]),
		.en_b   (en[2]),
		.v      (v0_s1),
		.c      (c_s1),
		.res_s2 (v1_s3)
	);

	fpexp_series u_series (
		.clk  (clk),
		.en   (en[4:1]),
		.dlow (dlow_s1),
		.zero (meta_q[3].zero),
		.s_s4 (s_s5)
	);

	// hold the coarse result until the series term is ready
	always_ff @(posedge clk) begin
		if (en[3]) begin
			v1_s4 <= v1_s3;
		end
		if (en[4]) begin
			v1_s5 <= v1_s4;
		end
	end

	fpexp_scale u_fine (
		.clk    (clk),
		.en_a   (en[5]),
		.en_b   (en[6]),
		.v      (v1_s5),
		.c      (s_s5),
		.res_s2 (v2_s7)
	);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			if (meta_q[6].sat_hi) begin
				value_s8 <= SAT_HIGH;
			end else if (meta_q[6].sat_lo) begin
				value_s8 <= '0;
			end else if (meta_q[6].func) begin
				value_s8 <= v2_s7[31:0];
			end else begin
				value_s8 <= v2_s7[48:17];
			end
		end
	end

`ifndef SYNTHESIS
	a_sat_hi: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && meta_q[NSTG-1].sat_hi |-> value == SAT_HIGH)
		else $error("saturated item has wrong value");

	a_sat_lo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && meta_q[NSTG-1].sat_lo && !meta_q[NSTG-1].sat_hi |-> value == '0)
		else $error("underflow item has nonzero value");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_q == '1)
		else $error("input blocked while a stage is empty");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[3] && !en[3] |=> valid_q[3] && $stable(v1_s4))
		else $error("stalled stage lost its item");
`endif

endmodule
